// ===== hw/rtl/ffa_pkg.sv =====
// Shared constants, codes and types of the first-fit segment allocator.
package ffa_pkg;

	localparam int ADDR_W        = 48;
	localparam int FREE_SEGMENTS = 32;
	localparam int GRANT_ENTRIES = 64;
	// Alignment granule; it must be a power of two.
	localparam int ALIGN_BYTES   = 64;

	localparam int FI_W = $clog2(FREE_SEGMENTS);
	localparam int CNT_W = $clog2(FREE_SEGMENTS + 1);
	localparam int M_W = $clog2(FREE_SEGMENTS + 2);
	localparam int GI_W = $clog2(GRANT_ENTRIES);
	localparam int GC_W = $clog2(GRANT_ENTRIES + 1);

	localparam logic [ADDR_W-1:0] POOL_START_RST  = 48'd268439552;
	localparam logic [ADDR_W-1:0] POOL_LENGTH_RST = 48'd268431360;

	typedef enum logic [1:0] {
		STS_OK,
		STS_NOMEM,
		STS_UNKNOWN,
		STS_FULL
	} status_t;

	typedef enum logic {
		REG_POOL_START,
		REG_POOL_LENGTH
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_RD,
		S_A_CHK,
		S_A_SLOT,
		S_A_SHRD,
		S_A_SHWR,
		S_F_RD,
		S_F_CHK,
		S_M_RD,
		S_M_PROC,
		S_M_INS,
		S_M_FLUSH,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] length;
	} seg_t;

endpackage

// ===== hw/rtl/ffa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/first_fit_segment_allocator.sv =====
// Top level of the first-fit segment allocator with free-segment coalescing.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  in      | to block  | in_valid / in_stall   | opcode, request_length, release_address
//  out     | from block| out_valid / out_stall | granted_address, status
//  cfg     | to block  | cfg_we                | cfg_index, cfg_data
//
// One word is worked on at a time; each RAM entry visit is a read state, then a check state.
// An allocate walks the free segments, scans the grant slots and shifts the segments
// that follow a removed one. A free looks up the grant table, then makes two merge passes
// over the free list: a counting pass and a writing pass.
// After reset and after every configuration write, free-list entry zero is rewritten
// before the next word is taken. A finished result waits in an output register, so a
// stalled output holds only the next result, not the next accept.
module first_fit_segment_allocator import ffa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              opcode,
	input  logic [ADDR_W-1:0] request_length,
	input  logic [ADDR_W-1:0] release_address,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ADDR_W-1:0] granted_address,
	output logic [1:0]        status,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [ADDR_W-1:0] cfg_data
);

	localparam logic [ADDR_W:0] ALIGN_MASK = (ADDR_W+1)'(ALIGN_BYTES - 1);
	localparam logic [ADDR_W:0] SPACE_END = {1'b1, {ADDR_W{1'b0}}};

	state_t state_q, state_d;

	// Configuration and free-list bookkeeping.
	logic [ADDR_W-1:0] pool_start_q, pool_length_q;
	logic              init_pend_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [GRANT_ENTRIES-1:0] gvalid_q;

	// Captured request and scan state.
	logic [ADDR_W:0]   len_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  idx_q;
	logic [GC_W-1:0]   gidx_q;
	logic [FI_W-1:0]   seg_q;
	logic [ADDR_W-1:0] segs_q, segl_q;
	logic [GI_W-1:0]   gslot_q;
	logic [ADDR_W-1:0] s_q, l_q;
	seg_t              hold_q;

	// Merge accumulator.
	logic [ADDR_W-1:0] acc_s_q, acc_l_q;
	logic              accv_q, placed_q, pass2_q;
	logic [M_W-1:0]    m_q;

	// Result staging and output register.
	logic [ADDR_W-1:0] res_addr_q, out_addr_q;
	status_t           res_sts_q, out_sts_q;
	logic              out_valid_q;

	// RAM ports.
	seg_t            frd, grd, fw_data, gw_data;
	logic            fw_en, gw_en;
	logic [FI_W-1:0] fr_addr, fw_addr;
	logic [GI_W-1:0] gr_addr;

	// Merge feed.
	logic              feed_en;
	logic [ADDR_W-1:0] feed_st, feed_ln;
	logic [ADDR_W:0]   acc_end, fd_end, fd_nl;
	logic              fd_merge, fd_grow;
	logic [ADDR_W-1:0] fd_nl_sat;

	logic              in_acc, out_free, idx_end, g_end, fit, exact, hit, ins_here;
	logic [GI_W-1:0]   gi;
	logic [ADDR_W-1:0] init_len, req_nz;
	logic [ADDR_W:0]   room, rounded;

	ffa_ram #(.WIDTH($bits(seg_t)), .DEPTH(FREE_SEGMENTS)) u_free_ram (
		.clk(clk), .we(fw_en), .waddr(fw_addr), .wdata(fw_data),
		.raddr(fr_addr), .rdata(frd)
	);

	ffa_ram #(.WIDTH($bits(seg_t)), .DEPTH(GRANT_ENTRIES)) u_grant_ram (
		.clk(clk), .we(gw_en), .waddr(gidx_q[GI_W-1:0]), .wdata(gw_data),
		.raddr(gr_addr), .rdata(grd)
	);

	assign in_stall = !(state_q == S_IDLE && !init_pend_q);
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign granted_address = out_addr_q;
	assign status = out_sts_q;

	// The initial segment is cut so that it never runs past the top of the address space.
	assign room = SPACE_END - {1'b0, pool_start_q};
	assign init_len = ({1'b0, pool_length_q} < room) ? pool_length_q : room[ADDR_W-1:0];

	// A zero-length request is served as one granule, then rounded up to the granule.
	assign req_nz = (request_length == '0) ? ADDR_W'(ALIGN_BYTES) : request_length;
	assign rounded = ({1'b0, req_nz} + ALIGN_MASK) & ~ALIGN_MASK;

	assign gi = gidx_q[GI_W-1:0];
	assign idx_end = (idx_q == cnt_q);
	assign g_end = (gidx_q == GC_W'(GRANT_ENTRIES));
	assign fit = ({1'b0, frd.length} >= len_q);
	assign exact = ({1'b0, segl_q} == len_q);
	assign hit = gvalid_q[gi] && (grd.start == addr_q);
	assign ins_here = !placed_q && (frd.start > s_q);

	// Touching or overlapping segments fold into the accumulator; the length saturates.
	assign acc_end = {1'b0, acc_s_q} + {1'b0, acc_l_q};
	assign fd_end = {1'b0, feed_st} + {1'b0, feed_ln};
	assign fd_merge = accv_q && (acc_end >= {1'b0, feed_st});
	assign fd_grow = fd_end > acc_end;
	assign fd_nl = fd_end - {1'b0, acc_s_q};
	assign fd_nl_sat = fd_nl[ADDR_W] ? {ADDR_W{1'b1}} : fd_nl[ADDR_W-1:0];

	assign gw_data = '{start: segs_q, length: len_q[ADDR_W-1:0]};

	always_comb begin
		state_d = state_q;
		fr_addr = idx_q[FI_W-1:0];
		gr_addr = gi;
		fw_en = 1'b0;
		fw_addr = seg_q;
		fw_data = '{start: acc_s_q, length: acc_l_q};
		gw_en = 1'b0;
		feed_en = 1'b0;
		feed_st = s_q;
		feed_ln = l_q;
		unique case (state_q)
			S_IDLE: begin
				if (init_pend_q) begin
					fw_en = 1'b1;
					fw_addr = '0;
					fw_data = '{start: pool_start_q, length: init_len};
				end else if (in_valid) begin
					state_d = opcode ? S_F_RD : S_A_RD;
				end
			end
			S_A_RD: state_d = idx_end ? S_FIN : S_A_CHK;
			S_A_CHK: state_d = fit ? S_A_SLOT : S_A_RD;
			S_A_SLOT: begin
				if (g_end) begin
					state_d = S_FIN;
				end else if (!gvalid_q[gi]) begin
					gw_en = 1'b1;
					if (exact) begin
						state_d = S_A_SHRD;
					end else begin
						fw_en = 1'b1;
						fw_addr = seg_q;
						fw_data = '{start: segs_q + len_q[ADDR_W-1:0],
							length: segl_q - len_q[ADDR_W-1:0]};
						state_d = S_FIN;
					end
				end
			end
			S_A_SHRD: state_d = idx_end ? S_FIN : S_A_SHWR;
			S_A_SHWR: begin
				fw_en = 1'b1;
				fw_addr = FI_W'(idx_q - CNT_W'(1));
				fw_data = frd;
				state_d = S_A_SHRD;
			end
			S_F_RD: state_d = g_end ? S_FIN : S_F_CHK;
			S_F_CHK: state_d = hit ? S_M_RD : S_F_RD;
			S_M_RD: begin
				if (idx_end) begin
					if (!placed_q) begin
						feed_en = 1'b1;
					end else begin
						state_d = S_M_FLUSH;
					end
				end else begin
					state_d = S_M_PROC;
				end
			end
			S_M_PROC: begin
				feed_en = 1'b1;
				if (ins_here) begin
					state_d = S_M_INS;
				end else begin
					feed_st = frd.start;
					feed_ln = frd.length;
					state_d = S_M_RD;
				end
			end
			S_M_INS: begin
				feed_en = 1'b1;
				feed_st = hold_q.start;
				feed_ln = hold_q.length;
				state_d = S_M_RD;
			end
			S_M_FLUSH: begin
				if (!pass2_q) begin
					state_d = (m_q > M_W'(FREE_SEGMENTS)) ? S_FIN : S_M_RD;
				end else begin
					fw_en = 1'b1;
					fw_addr = FI_W'(m_q - M_W'(1));
					state_d = S_FIN;
				end
			end
			S_FIN: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		// In the writing pass a closed segment goes back in place; its entry was already read.
		if (feed_en && pass2_q && accv_q && !fd_merge) begin
			fw_en = 1'b1;
			fw_addr = FI_W'(m_q - M_W'(1));
			fw_data = '{start: acc_s_q, length: acc_l_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_start_q <= POOL_START_RST;
			pool_length_q <= POOL_LENGTH_RST;
			init_pend_q <= 1'b1;
			cnt_q <= CNT_W'(1);
			gvalid_q <= '0;
			idx_q <= '0;
			gidx_q <= '0;
			m_q <= '0;
			accv_q <= 1'b0;
			placed_q <= 1'b0;
			pass2_q <= 1'b0;
			out_valid_q <= 1'b0;
			res_sts_q <= STS_OK;
			out_sts_q <= STS_OK;
		end else begin
			// The output register empties here unless a new result refills it below.
			if (out_valid_q && !out_stall && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (init_pend_q) begin
						cnt_q <= CNT_W'(1);
						if (!cfg_we) init_pend_q <= 1'b0;
					end else if (in_acc) begin
						len_q <= rounded;
						addr_q <= release_address;
						idx_q <= '0;
						gidx_q <= '0;
						res_addr_q <= '0;
					end
				end
				S_A_RD: if (idx_end) res_sts_q <= STS_NOMEM;
				S_A_CHK: begin
					if (fit) begin
						seg_q <= idx_q[FI_W-1:0];
						segs_q <= frd.start;
						segl_q <= frd.length;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_A_SLOT: begin
					if (g_end) begin
						res_sts_q <= STS_FULL;
					end else if (!gvalid_q[gi]) begin
						gvalid_q[gi] <= 1'b1;
						res_addr_q <= segs_q;
						res_sts_q <= STS_OK;
						if (exact) idx_q <= CNT_W'(seg_q) + CNT_W'(1);
					end else begin
						gidx_q <= gidx_q + GC_W'(1);
					end
				end
				S_A_SHRD: if (idx_end) cnt_q <= cnt_q - CNT_W'(1);
				S_A_SHWR: idx_q <= idx_q + CNT_W'(1);
				S_F_RD: if (g_end) res_sts_q <= STS_UNKNOWN;
				S_F_CHK: begin
					if (hit) begin
						s_q <= grd.start;
						l_q <= grd.length;
						gslot_q <= gi;
						idx_q <= '0;
						m_q <= '0;
						placed_q <= 1'b0;
						accv_q <= 1'b0;
						pass2_q <= 1'b0;
					end else begin
						gidx_q <= gidx_q + GC_W'(1);
					end
				end
				S_M_RD: if (idx_end && !placed_q) placed_q <= 1'b1;
				S_M_PROC: begin
					if (ins_here) begin
						placed_q <= 1'b1;
						hold_q <= frd;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_M_INS: idx_q <= idx_q + CNT_W'(1);
				S_M_FLUSH: begin
					if (!pass2_q) begin
						if (m_q > M_W'(FREE_SEGMENTS)) begin
							res_sts_q <= STS_FULL;
						end else begin
							pass2_q <= 1'b1;
							idx_q <= '0;
							m_q <= '0;
							placed_q <= 1'b0;
							accv_q <= 1'b0;
						end
					end else begin
						cnt_q <= CNT_W'(m_q);
						gvalid_q[gslot_q] <= 1'b0;
						res_sts_q <= STS_OK;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_addr_q <= res_addr_q;
						out_sts_q <= res_sts_q;
					end
				end
				default: ;
			endcase
			if (feed_en) begin
				if (fd_merge) begin
					if (fd_grow) acc_l_q <= fd_nl_sat;
				end else begin
					acc_s_q <= feed_st;
					acc_l_q <= feed_ln;
					accv_q <= 1'b1;
					m_q <= m_q + M_W'(1);
				end
			end
			// A configuration write always schedules a fresh rebuild.
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_POOL_START: pool_start_q <= cfg_data;
					REG_POOL_LENGTH: pool_length_q <= cfg_data;
				endcase
				init_pend_q <= 1'b1;
			end
		end
	end

	// The free list never holds more entries than its RAM.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FREE_SEGMENTS))
		else $error("free segment count beyond capacity");

	// An accepted word always leaves the idle state.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != S_IDLE)
		else $error("accepted word did not start work");

	// Only a successful allocate reports a nonzero address.
	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_sts_q != STS_OK |-> out_addr_q == '0)
		else $error("failed request carries an address");

	// The writing pass of a free only runs after an overflow-free counting pass.
	a_commit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_M_FLUSH && pass2_q |-> m_q != '0 && m_q <= M_W'(FREE_SEGMENTS))
		else $error("merge commit with bad segment count");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the first-fit segment allocator.
`timescale 1ns / 1ps

module tb;
	import ffa_pkg::*;

	typedef struct {
		logic              op;
		logic [ADDR_W-1:0] req_len;
		logic [ADDR_W-1:0] rel_addr;
	} word_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		status_t           sts;
	} answer_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;
	localparam longint unsigned MASK = 64'hFFFF_FFFF_FFFF;
	localparam longint unsigned SPACE = 64'h1_0000_0000_0000;
	localparam int LIMIT = 2_000_000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              opcode = 1'b0;
	logic [ADDR_W-1:0] request_length = '0;
	logic [ADDR_W-1:0] release_address = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [ADDR_W-1:0] granted_address;
	logic [1:0]        status;
	logic              cfg_we = 1'b0;
	logic              cfg_index = 1'b0;
	logic [ADDR_W-1:0] cfg_data = '0;

	first_fit_segment_allocator u_dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// Mirror of the allocator state: free list, grant table and pool registers.
	longint unsigned pool_base, pool_len;
	longint unsigned seg_base[FREE_SEGMENTS], seg_len[FREE_SEGMENTS];
	int              seg_count;
	longint unsigned gr_base[GRANT_ENTRIES], gr_len[GRANT_ENTRIES];
	bit              gr_used[GRANT_ENTRIES];

	word_t   pending_words[$];
	answer_t expected_answers[$];
	longint unsigned live_addrs[$];
	int      mismatches = 0;
	int      cycles = 0;
	bit      quiet_mode = 1'b0;

	function automatic void reload_free_list();
		longint unsigned room;
		room = SPACE - pool_base;
		for (int i = 0; i < FREE_SEGMENTS; i++) begin
			seg_base[i] = 0;
			seg_len[i] = 0;
		end
		seg_base[0] = pool_base;
		seg_len[0] = (pool_len < room) ? pool_len : room;
		if (seg_len[0] > MASK)
			seg_len[0] = MASK;
		seg_count = 1;
	endfunction

	function automatic status_t model_alloc(longint unsigned req, output longint unsigned addr);
		longint unsigned len;
		int seg, slot;
		len = (req == 0) ? ALIGN_BYTES : req;
		len = ((len + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
		seg = -1;
		slot = -1;
		addr = 0;
		for (int i = 0; i < seg_count; i++)
			if (seg < 0 && seg_len[i] >= len)
				seg = i;
		if (seg < 0)
			return STS_NOMEM;
		for (int i = 0; i < GRANT_ENTRIES; i++)
			if (slot < 0 && !gr_used[i])
				slot = i;
		if (slot < 0)
			return STS_FULL;
		addr = seg_base[seg];
		gr_base[slot] = seg_base[seg];
		gr_len[slot] = len;
		gr_used[slot] = 1'b1;
		if (seg_len[seg] == len) begin
			for (int k = seg; k + 1 < seg_count; k++) begin
				seg_base[k] = seg_base[k+1];
				seg_len[k] = seg_len[k+1];
			end
			seg_count--;
			seg_base[seg_count] = 0;
			seg_len[seg_count] = 0;
		end else begin
			seg_base[seg] = (seg_base[seg] + len) & MASK;
			seg_len[seg] -= len;
		end
		return STS_OK;
	endfunction

	function automatic status_t model_release(longint unsigned addr);
		longint unsigned ib[FREE_SEGMENTS+1], il[FREE_SEGMENTS+1];
		longint unsigned mb[FREE_SEGMENTS+1], ml[FREE_SEGMENTS+1];
		longint unsigned s, l, e, nl;
		int g, n, m;
		bit placed;
		g = -1;
		n = 0;
		m = 0;
		placed = 1'b0;
		for (int i = 0; i < GRANT_ENTRIES; i++)
			if (g < 0 && gr_used[i] && gr_base[i] == addr)
				g = i;
		if (g < 0)
			return STS_UNKNOWN;
		s = gr_base[g];
		l = gr_len[g];
		for (int i = 0; i < seg_count; i++) begin
			if (!placed && seg_base[i] > s) begin
				ib[n] = s; il[n] = l; n++; placed = 1'b1;
			end
			ib[n] = seg_base[i]; il[n] = seg_len[i]; n++;
		end
		if (!placed) begin
			ib[n] = s; il[n] = l; n++;
		end
		// Coalesce neighbors that touch or overlap; sums stay within 64 bits.
		for (int i = 0; i < n; i++) begin
			e = ib[i] + il[i];
			if (m > 0 && mb[m-1] + ml[m-1] >= ib[i]) begin
				if (e > mb[m-1] && e - mb[m-1] > ml[m-1]) begin
					nl = e - mb[m-1];
					ml[m-1] = (nl > MASK) ? MASK : nl;
				end
			end else begin
				mb[m] = ib[i]; ml[m] = il[i]; m++;
			end
		end
		if (m > FREE_SEGMENTS)
			return STS_FULL;
		gr_used[g] = 1'b0;
		for (int i = 0; i < FREE_SEGMENTS; i++) begin
			seg_base[i] = (i < m) ? mb[i] : 0;
			seg_len[i] = (i < m) ? ml[i] : 0;
		end
		seg_count = m;
		return STS_OK;
	endfunction

	// Works out the answer of one accepted word and advances the mirror.
	function automatic answer_t predict_answer(word_t w);
		answer_t a;
		longint unsigned addr;
		addr = 0;
		if (w.op == OP_ALLOC)
			a.sts = model_alloc(w.req_len, addr);
		else
			a.sts = model_release(w.rel_addr);
		a.addr = (a.sts == STS_OK) ? addr[ADDR_W-1:0] : '0;
		return a;
	endfunction

	// Driver: presents words from the pending queue; a held word stays put while stalled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_answers = {expected_answers, predict_answer(
					'{op: opcode, req_len: request_length, rel_addr: release_address})};
			end
			if (!in_valid || !in_stall) begin
				if (pending_words.size() > 0 && (quiet_mode || $urandom_range(99) >= 34)) begin
					word_t w;
					w = pending_words[0];
					pending_words.delete(0);
					in_valid <= 1'b1;
					opcode <= w.op;
					request_length <= w.req_len;
					release_address <= w.rel_addr;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares every accepted result with the oldest expectation.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			out_stall <= quiet_mode ? 1'b0 : ($urandom_range(99) < 34);
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result addr=%h status=%0d", granted_address, status);
				end else begin
					answer_t a;
					a = expected_answers[0];
					expected_answers.delete(0);
					if (a.addr !== granted_address || a.sts !== status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
								a.addr, a.sts, granted_address, status);
					end
				end
			end
		end
	end

	initial begin
		while (cycles < LIMIT)
			@(posedge clk);
		$display("tb NOT OK");
		$finish;
	end

	function automatic void queue_word(logic op, longint unsigned len, longint unsigned addr);
		pending_words = {pending_words,
			word_t'{op: op, req_len: len[ADDR_W-1:0], rel_addr: addr[ADDR_W-1:0]}};
	endfunction

	function automatic longint unsigned rand48();
		return {$urandom(), $urandom()} & MASK;
	endfunction

	// Blocks until every queued word has been answered, plus a short settling time.
	task automatic drain();
		while (pending_words.size() > 0 || in_valid || expected_answers.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, longint unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[ADDR_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_POOL_START)
			pool_base = value & MASK;
		else
			pool_len = value & MASK;
		reload_free_list();
	endtask

	// Random words: mostly frees of live grants and modest allocations.
	task automatic random_phase(int count);
		int k;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(99);
			if (k < 45)
				queue_word(OP_ALLOC, $urandom_range(300), rand48());
			else if (k < 50)
				queue_word(OP_ALLOC, rand48(), rand48());
			else if (k < 90 && live_addrs.size() > 0)
				queue_word(OP_FREE, rand48(), live_addrs[$urandom_range(live_addrs.size() - 1)]);
			else
				queue_word(OP_FREE, rand48(), rand48());
		end
	endtask

	initial begin
		pool_base = POOL_START_RST;
		pool_len = POOL_LENGTH_RST;
		reload_free_list();
		for (int i = 0; i < GRANT_ENTRIES; i++)
			gr_used[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// Directed: zero, odd and huge lengths, unknown frees and a duplicate free.
		queue_word(OP_ALLOC, 0, MASK);
		queue_word(OP_ALLOC, 1, 0);
		queue_word(OP_ALLOC, MASK, 0);
		queue_word(OP_ALLOC, 65, 0);
		queue_word(OP_FREE, MASK, 48'h1234);
		queue_word(OP_FREE, 0, POOL_START_RST + 64);
		queue_word(OP_FREE, 0, POOL_START_RST);
		queue_word(OP_FREE, 0, POOL_START_RST);
		drain();

		// Tiny pool at the top of the address space with a table-filling burst.
		write_reg(REG_POOL_START, MASK - 48'h3FFF);
		write_reg(REG_POOL_LENGTH, MASK);
		for (int i = 0; i < 66; i++)
			queue_word(OP_ALLOC, 64, 0);
		drain();
		// Free every other grant so the free list fragments, then the rest.
		for (int i = 0; i < 64; i += 2)
			queue_word(OP_FREE, 0, MASK - 48'h3FFF + 64 * i);
		for (int i = 1; i < 64; i += 2)
			queue_word(OP_FREE, 0, MASK - 48'h3FFF + 64 * i);
		drain();

		// Random phases over several pool settings, including zero and full length.
		for (int phase = 0; phase < 6; phase++) begin
			longint unsigned base;
			base = (phase == 0) ? 0 : (phase == 1) ? MASK : (rand48() & ~64'hFFF);
			write_reg(REG_POOL_START, base);
			write_reg(REG_POOL_LENGTH, (phase == 2) ? 0 : (phase == 3) ? MASK :
				64 * $urandom_range(20, 200));
			// Releases of stale grants still match, so offer the candidates the mirror holds.
			live_addrs.delete();
			for (int i = 0; i < 40; i++)
				live_addrs = {live_addrs, base + 64 * $urandom_range(0, 199)};
			for (int i = 0; i < GRANT_ENTRIES; i++)
				if (gr_used[i])
					live_addrs = {live_addrs, gr_base[i]};
			quiet_mode = (phase == 4);
			random_phase(180);
			drain();
		end

		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
